// File: src/vfc_pkg.sv
// vfc_pkg: shared types, constants and the corner occlusion function
// used by the front, queue and back of the voxel face cull block
// no dependencies
`default_nettype none

package vfc_pkg;

  localparam int unsigned NUM_FACES = 6;
  localparam int unsigned NUM_CORNERS = 4;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // dy = -1 cells and dy = +1 cells of the neighborhood mask
  localparam logic [26:0] BELOW_MASK = 27'h01C0E07;
  localparam logic [26:0] ABOVE_MASK = 27'h70381C0;

  // mask bit of the face neighbor, order -x +x -y +y -z +z
  localparam logic [4:0] FACE_NBR_BIT [NUM_FACES] = '{
    5'd4, 5'd22, 5'd10, 5'd16, 5'd12, 5'd14
  };

  // corner offsets per face, bit2 = x, bit1 = y, bit0 = z
  localparam logic [2:0] FACE_CORNERS [NUM_FACES][NUM_CORNERS] = '{
    '{3'd0, 3'd1, 3'd3, 3'd2},
    '{3'd5, 3'd4, 3'd6, 3'd7},
    '{3'd1, 3'd0, 3'd4, 3'd5},
    '{3'd2, 3'd3, 3'd7, 3'd6},
    '{3'd4, 3'd0, 3'd2, 3'd6},
    '{3'd1, 3'd5, 3'd7, 3'd3}
  };

  typedef struct packed {
    logic [26:0] mask;
    logic [7:0]  kind;
    logic [3:0]  x;
    logic [7:0]  y;
    logic [3:0]  z;
    logic [5:0]  faces;
  } vfc_item_t;

  typedef struct packed {
    logic push;
    logic full;
  } vfc_wr_ctl_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } vfc_rd_ctl_t;

  function automatic logic [1:0] corner_count(input logic [26:0] m,
                                              input logic [1:0]  axis,
                                              input logic [2:0]  corner);
    logic [4:0] cx;
    logic [4:0] cy;
    logic [4:0] cz;
    logic [1:0] n;
    cx = corner[2] ? 5'd18 : 5'd0;
    cy = corner[1] ? 5'd6 : 5'd0;
    cz = corner[0] ? 5'd2 : 5'd0;
    n = {1'b0, m[cx + cy + cz]};
    if (axis != AXIS_X) n = n + {1'b0, m[5'd9 + cy + cz]};
    if (axis != AXIS_Y) n = n + {1'b0, m[cx + 5'd3 + cz]};
    if (axis != AXIS_Z) n = n + {1'b0, m[cx + cy + 5'd1]};
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/voxel_face_cull_ambient_occlusion_top.sv
// a block is registered in the queue, and its first face then in the result register
// throughput: the back emits one face per cycle unless out_ready stalls; a block gives
// 1 to 6 faces; air and fully enclosed blocks are dropped at the front and never queued
// input takes one block a cycle while the two-entry block queue has room
// reset: synchronous, active low, empties the queue, the face walk and the result register
`default_nettype none

module voxel_face_cull_ambient_occlusion_top #(
  parameter int CHUNK_TALL = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [26:0] in_solid_mask,
  input  wire logic [7:0]  in_block_kind,
  input  wire logic [3:0]  in_pos_x,
  input  wire logic [7:0]  in_pos_y,
  input  wire logic [3:0]  in_pos_z,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_face_id,
  output logic [1:0]       out_occl_v0,
  output logic [1:0]       out_occl_v1,
  output logic [1:0]       out_occl_v2,
  output logic [1:0]       out_occl_v3,
  output logic [7:0]       out_kind,
  output logic [3:0]       out_x,
  output logic [7:0]       out_y,
  output logic [3:0]       out_z,
  output logic             out_last_face
);
  import vfc_pkg::*;

  vfc_item_t   wr_item;
  vfc_item_t   rd_item;
  vfc_wr_ctl_t wr_ctl;
  vfc_rd_ctl_t rd_ctl;
  logic        q_full;
  logic        q_push;
  logic        q_pop;

  assign wr_ctl.push = q_push;
  assign wr_ctl.full = q_full;

  vfc_front #(
    .CHUNK_TALL(CHUNK_TALL)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_solid_mask (in_solid_mask),
    .in_block_kind (in_block_kind),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_pos_z      (in_pos_z),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (wr_item)
  );

  vfc_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_in   (wr_ctl),
    .full    (q_full),
    .wr_item (wr_item),
    .pop     (q_pop),
    .rd_out  (rd_ctl),
    .rd_item (rd_item)
  );

  vfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_ctl         (rd_ctl),
    .q_item        (rd_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_face_id   (out_face_id),
    .out_occl_v0   (out_occl_v0),
    .out_occl_v1   (out_occl_v1),
    .out_occl_v2   (out_occl_v2),
    .out_occl_v3   (out_occl_v3),
    .out_kind      (out_kind),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_z         (out_z),
    .out_last_face (out_last_face)
  );

endmodule

`default_nettype wire

// File: src/vfc_front.sv
// vfc_front: takes blocks, applies world top/bottom rules and finds visible faces
// depends on vfc_pkg
`default_nettype none

module vfc_front #(
  parameter int CHUNK_TALL = 256
) (
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [26:0]       in_solid_mask,
  input  wire logic [7:0]        in_block_kind,
  input  wire logic [3:0]        in_pos_x,
  input  wire logic [7:0]        in_pos_y,
  input  wire logic [3:0]        in_pos_z,
  input  wire logic              q_full,
  output logic                   q_push,
  output vfc_pkg::vfc_item_t     q_item
);
  import vfc_pkg::*;

  logic [26:0] mask_c;
  logic [5:0]  faces_c;
  logic        at_top;

  assign at_top = (32'({24'd0, in_pos_y}) + 32'd1) >= 32'(CHUNK_TALL);

  always_comb begin
    mask_c = in_solid_mask;
    if (in_pos_y == 8'd0) mask_c = mask_c & ~BELOW_MASK;
    if (at_top) mask_c = mask_c & ~ABOVE_MASK;
    for (int f = 0; f < NUM_FACES; f++) begin
      faces_c[f] = ~mask_c[FACE_NBR_BIT[f]];
    end
  end

  assign in_ready = ~q_full;
  assign q_push = in_valid && ~q_full && (in_block_kind != 8'd0) && (faces_c != 6'd0);

  always_comb begin
    q_item.mask  = mask_c;
    q_item.kind  = in_block_kind;
    q_item.x     = in_pos_x;
    q_item.y     = in_pos_y;
    q_item.z     = in_pos_z;
    q_item.faces = faces_c;
  end

endmodule

`default_nettype wire

// File: src/vfc_queue.sv
// vfc_queue: two-entry queue of classified blocks between front and back
// depends on vfc_pkg
`default_nettype none

module vfc_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vfc_pkg::vfc_wr_ctl_t wr_in,
  output logic                     full,
  input  wire vfc_pkg::vfc_item_t  wr_item,
  input  wire logic                pop,
  output vfc_pkg::vfc_rd_ctl_t     rd_out,
  output vfc_pkg::vfc_item_t       rd_item
);
  import vfc_pkg::*;

  vfc_item_t  mem [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign full = (count_r == 2'd2);
  assign do_push = wr_in.push && !full;
  assign do_pop = pop && (count_r != 2'd0);

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= wr_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  assign rd_item = mem[rd_ptr_r];
  assign rd_out.empty = (count_r == 2'd0);
  assign rd_out.pop = do_pop;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_in.push |-> !full || !wr_in.full)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != 2'd0)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != 2'd3)
    else $error("queue count overflow");

endmodule

`default_nettype wire

// File: src/vfc_back.sv
// vfc_back: walks the visible faces of the head block, one face a transfer,
// computes corner occlusion and holds the result register; depends on vfc_pkg
`default_nettype none

module vfc_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vfc_pkg::vfc_rd_ctl_t q_ctl,
  input  wire vfc_pkg::vfc_item_t  q_item,
  output logic                     q_pop,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               out_face_id,
  output logic [1:0]               out_occl_v0,
  output logic [1:0]               out_occl_v1,
  output logic [1:0]               out_occl_v2,
  output logic [1:0]               out_occl_v3,
  output logic [7:0]               out_kind,
  output logic [3:0]               out_x,
  output logic [7:0]               out_y,
  output logic [3:0]               out_z,
  output logic                     out_last_face
);
  import vfc_pkg::*;

  logic       busy_r;
  logic       busy_nxt;
  logic [5:0] rem_r;
  logic [5:0] rem_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic [2:0] face_r;
  logic [1:0] occl_r [NUM_CORNERS];
  logic [7:0] kind_r;
  logic [3:0] x_r;
  logic [7:0] y_r;
  logic [3:0] z_r;
  logic       last_r;

  logic [5:0] work;
  logic [2:0] face_c;
  logic [5:0] left_c;
  logic       load;
  logic [1:0] axis_c;
  logic [1:0] occl_c [NUM_CORNERS];

  always_comb begin
    work = busy_r ? rem_r : q_item.faces;
    face_c = 3'd0;
    for (int f = NUM_FACES - 1; f >= 0; f--) begin
      if (work[f]) face_c = 3'(f);
    end
    left_c = work & ~(6'd1 << face_c);
    axis_c = face_c[2:1];
    for (int v = 0; v < NUM_CORNERS; v++) begin
      occl_c[v] = corner_count(q_item.mask, axis_c, FACE_CORNERS[face_c][v]);
    end
  end

  assign load = !q_ctl.empty && (!valid_r || out_ready);
  assign q_pop = load && (left_c == 6'd0);

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    busy_nxt = busy_r;
    rem_nxt = rem_r;
    if (load) begin
      valid_nxt = 1'b1;
      busy_nxt = (left_c != 6'd0);
      rem_nxt = left_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      busy_r <= 1'b0;
      rem_r <= 6'd0;
    end else begin
      valid_r <= valid_nxt;
      busy_r <= busy_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      face_r <= face_c;
      occl_r <= occl_c;
      kind_r <= q_item.kind;
      x_r <= q_item.x;
      y_r <= q_item.y;
      z_r <= q_item.z;
      last_r <= (left_c == 6'd0);
    end
  end

  assign out_valid = valid_r;
  assign out_face_id = face_r;
  assign out_occl_v0 = occl_r[0];
  assign out_occl_v1 = occl_r[1];
  assign out_occl_v2 = occl_r[2];
  assign out_occl_v3 = occl_r[3];
  assign out_kind = kind_r;
  assign out_x = x_r;
  assign out_y = y_r;
  assign out_z = z_r;
  assign out_last_face = last_r;

  a_busy_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !q_ctl.empty && rem_r != 6'd0)
    else $error("face walk without a queued block");
  a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> face_r < 3'd6)
    else $error("face id out of range");
  a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (q_pop == !busy_nxt))
    else $error("block popped out of step with its last face");
  a_pop_taken: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop == q_ctl.pop)
    else $error("queue did not take the pop");

endmodule

`default_nettype wire

// File: test/tb_top.sv
// tb_top: self-checking bench for voxel_face_cull_ambient_occlusion_top, directed rows then
// random blocks under random stalls on both channels, checked against a face/occlusion predictor
// depends on src/vfc_pkg.sv and src/voxel_face_cull_ambient_occlusion_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vfc_pkg::*;

  localparam int WORLD_TALL = 256;
  localparam int RANDOM_BLOCKS = 300;
  localparam int HOLD_AFTER_BLOCKS = 90;
  localparam int HOLD_CYCLES = 250;

  localparam logic [2:0] FACE_NEG_X = 3'd0;
  localparam logic [2:0] FACE_POS_X = 3'd1;
  localparam logic [2:0] FACE_NEG_Y = 3'd2;
  localparam logic [2:0] FACE_POS_Y = 3'd3;
  localparam logic [2:0] FACE_NEG_Z = 3'd4;
  localparam logic [2:0] FACE_POS_Z = 3'd5;

  localparam logic [5:0] ALL_FACES = 6'h3F;
  localparam logic [5:0] NO_FACES = 6'h00;
  localparam logic [26:0] FULL_MASK = 27'h7FFFFFF;

  // corner order per face, bit2 = x, bit1 = y, bit0 = z
  localparam logic [2:0] CORNER_SEQ [6][4] = '{
    '{3'b000, 3'b001, 3'b011, 3'b010},
    '{3'b101, 3'b100, 3'b110, 3'b111},
    '{3'b001, 3'b000, 3'b100, 3'b101},
    '{3'b010, 3'b011, 3'b111, 3'b110},
    '{3'b100, 3'b000, 3'b010, 3'b110},
    '{3'b001, 3'b101, 3'b111, 3'b011}
  };

  typedef struct packed {
    logic [2:0] face;
    logic [1:0] v0;
    logic [1:0] v1;
    logic [1:0] v2;
    logic [1:0] v3;
    logic [7:0] kind;
    logic [3:0] x;
    logic [7:0] y;
    logic [3:0] z;
    logic       last;
  } face_rec_t;

  // typed rows: every face in faces is visible with zero occlusion
  typedef struct packed {
    logic [26:0] mask;
    logic [7:0]  kind;
    logic [3:0]  x;
    logic [7:0]  y;
    logic [3:0]  z;
    logic        typed;
    logic [5:0]  faces;
  } stim_row_t;

  localparam int NUM_DIRECTED = 21;
  localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{27'h0000000, 8'd1,   4'd0,  8'd0,   4'd0,  1'b1, ALL_FACES},
    '{27'h0000000, 8'd0,   4'd0,  8'd0,   4'd0,  1'b1, NO_FACES},
    '{FULL_MASK,   8'd255, 4'd15, 8'd128, 4'd15, 1'b1, NO_FACES},
    '{FULL_MASK,   8'd7,   4'd3,  8'd0,   4'd9,  1'b1, 6'(1 << FACE_NEG_Y)},
    '{FULL_MASK,   8'd200, 4'd12, 8'd255, 4'd4,  1'b1, 6'(1 << FACE_POS_Y)},
    '{FULL_MASK,   8'd0,   4'd15, 8'd255, 4'd15, 1'b1, NO_FACES},
    '{27'h0002000, 8'd3,   4'd5,  8'd17,  4'd6,  1'b1, ALL_FACES},
    '{27'h7FFDFFF, 8'd9,   4'd8,  8'd40,  4'd8,  1'b1, NO_FACES},
    '{27'h0000000, 8'd255, 4'd15, 8'd255, 4'd15, 1'b1, ALL_FACES},
    '{27'h7FFFFEF, 8'd10,  4'd1,  8'd100, 4'd2,  1'b0, NO_FACES},
    '{27'h7BFFFFF, 8'd11,  4'd2,  8'd100, 4'd3,  1'b0, NO_FACES},
    '{27'h7FFFBFF, 8'd12,  4'd3,  8'd100, 4'd4,  1'b0, NO_FACES},
    '{27'h7FEFFFF, 8'd13,  4'd4,  8'd100, 4'd5,  1'b0, NO_FACES},
    '{27'h7FFEFFF, 8'd14,  4'd5,  8'd100, 4'd6,  1'b0, NO_FACES},
    '{27'h7FFBFFF, 8'd15,  4'd6,  8'd100, 4'd7,  1'b0, NO_FACES},
    '{27'h7BEABEF, 8'd16,  4'd7,  8'd50,  4'd8,  1'b0, NO_FACES},
    '{27'h5555555, 8'd128, 4'd15, 8'd0,   4'd0,  1'b0, NO_FACES},
    '{27'h2AAAAAA, 8'd1,   4'd0,  8'd255, 4'd15, 1'b0, NO_FACES},
    '{27'h5555555, 8'd77,  4'd1,  8'd254, 4'd2,  1'b0, NO_FACES},
    '{27'h2AAAAAA, 8'd254, 4'd14, 8'd1,   4'd13, 1'b0, NO_FACES},
    '{27'h1234567, 8'd42,  4'd10, 8'd128, 4'd5,  1'b0, NO_FACES}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [26:0] in_solid_mask = '0;
  logic [7:0]  in_block_kind = '0;
  logic [3:0]  in_pos_x = '0;
  logic [7:0]  in_pos_y = '0;
  logic [3:0]  in_pos_z = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_face_id;
  logic [1:0]  out_occl_v0;
  logic [1:0]  out_occl_v1;
  logic [1:0]  out_occl_v2;
  logic [1:0]  out_occl_v3;
  logic [7:0]  out_kind;
  logic [3:0]  out_x;
  logic [7:0]  out_y;
  logic [3:0]  out_z;
  logic        out_last_face;

  face_rec_t pending_faces [$];
  int        mismatches = 0;
  int        blocks_sent = 0;
  bit        burst_mode = 1'b0;

  voxel_face_cull_ambient_occlusion_top #(
    .CHUNK_TALL(WORLD_TALL)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_solid_mask(in_solid_mask),
    .in_block_kind(in_block_kind),
    .in_pos_x(in_pos_x),
    .in_pos_y(in_pos_y),
    .in_pos_z(in_pos_z),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_face_id(out_face_id),
    .out_occl_v0(out_occl_v0),
    .out_occl_v1(out_occl_v1),
    .out_occl_v2(out_occl_v2),
    .out_occl_v3(out_occl_v3),
    .out_kind(out_kind),
    .out_x(out_x),
    .out_y(out_y),
    .out_z(out_z),
    .out_last_face(out_last_face)
  );

  always #5 clk = ~clk;

  function automatic logic cell_at(input logic [26:0] m, input int dx, input int dy,
                                   input int dz);
    return m[dx * 9 + dy * 3 + dz];
  endfunction

  function automatic logic [1:0] occl_count(input logic [26:0] m, input int axis,
                                            input logic [2:0] corner);
    int cx;
    int cy;
    int cz;
    int n;
    cx = corner[2] ? 2 : 0;
    cy = corner[1] ? 2 : 0;
    cz = corner[0] ? 2 : 0;
    n = cell_at(m, cx, cy, cz);
    if (axis != int'(AXIS_X)) n += cell_at(m, 1, cy, cz);
    if (axis != int'(AXIS_Y)) n += cell_at(m, cx, 1, cz);
    if (axis != int'(AXIS_Z)) n += cell_at(m, cx, cy, 1);
    return n[1:0];
  endfunction

  function automatic void visible_faces(input logic [26:0] mask_in, input logic [7:0] kind,
                                        input logic [3:0] px, input logic [7:0] py,
                                        input logic [3:0] pz);
    logic [26:0] m;
    logic [5:0]  vis;
    face_rec_t   rec;
    int          axis;
    int          side;
    m = mask_in;
    vis = '0;
    if (kind == 8'd0) return;
    for (int dx = 0; dx < 3; dx++) begin
      for (int dz = 0; dz < 3; dz++) begin
        if (py == 8'd0) m[dx * 9 + dz] = 1'b0;
        if (int'(py) + 1 >= WORLD_TALL) m[dx * 9 + 6 + dz] = 1'b0;
      end
    end
    for (int f = 0; f < 6; f++) begin
      axis = f >> 1;
      side = (f & 1) ? 2 : 0;
      vis[f] = !cell_at(m, axis == 0 ? side : 1, axis == 1 ? side : 1, axis == 2 ? side : 1);
    end
    for (int f = 0; f < 6; f++) begin
      if (vis[f]) begin
        axis = f >> 1;
        rec.face = 3'(f);
        rec.v0 = occl_count(m, axis, CORNER_SEQ[f][0]);
        rec.v1 = occl_count(m, axis, CORNER_SEQ[f][1]);
        rec.v2 = occl_count(m, axis, CORNER_SEQ[f][2]);
        rec.v3 = occl_count(m, axis, CORNER_SEQ[f][3]);
        rec.kind = kind;
        rec.x = px;
        rec.y = py;
        rec.z = pz;
        rec.last = ((vis >> (f + 1)) == 6'd0);
        pending_faces.push_back(rec);
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want,
                             input face_rec_t exp_rec);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h want %0h (block %0d,%0d,%0d face %0d)",
                                name, got, want, exp_rec.x, exp_rec.y, exp_rec.z,
                                exp_rec.face));
  endtask

  task automatic send_block(input stim_row_t row);
    face_rec_t rec;
    int        gap;
    int        r;
    @(negedge clk);
    in_valid = 1'b1;
    in_solid_mask = row.mask;
    in_block_kind = row.kind;
    in_pos_x = row.x;
    in_pos_y = row.y;
    in_pos_z = row.z;
    do @(posedge clk); while (!in_ready);
    blocks_sent++;
    if (row.typed) begin
      for (int f = 0; f < 6; f++) begin
        if (row.faces[f]) begin
          rec = '0;
          rec.face = 3'(f);
          rec.kind = row.kind;
          rec.x = row.x;
          rec.y = row.y;
          rec.z = row.z;
          rec.last = ((row.faces >> (f + 1)) == 6'd0);
          pending_faces.push_back(rec);
        end
      end
    end else begin
      visible_faces(row.mask, row.kind, row.x, row.y, row.z);
    end
    r = $urandom_range(0, 99);
    if (burst_mode || r < 70) gap = 0;
    else if (r < 95) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 30);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // sink side: random stalls plus one long hold to back the block up
  initial begin
    int  stall_left;
    int  hold_left;
    bit  hold_done;
    int  r;
    stall_left = 0;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && blocks_sent >= HOLD_AFTER_BLOCKS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if (burst_mode) begin
        out_ready = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready = 1'b1;
        end else if (r < 95) begin
          out_ready = 1'b0;
          stall_left = $urandom_range(0, 2);
        end else begin
          out_ready = 1'b0;
          stall_left = $urandom_range(5, 20);
        end
      end
    end
  end

  always @(posedge clk) begin
    face_rec_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_faces.size() == 0) begin
        report_mismatch($sformatf("unexpected face transfer, face %0d block %0d,%0d,%0d",
                                  out_face_id, out_x, out_y, out_z));
      end else begin
        want = pending_faces.pop_front();
        check_field("face_id", 8'(out_face_id), 8'(want.face), want);
        check_field("occl_v0", 8'(out_occl_v0), 8'(want.v0), want);
        check_field("occl_v1", 8'(out_occl_v1), 8'(want.v1), want);
        check_field("occl_v2", 8'(out_occl_v2), 8'(want.v2), want);
        check_field("occl_v3", 8'(out_occl_v3), 8'(want.v3), want);
        check_field("kind", out_kind, want.kind, want);
        check_field("x", 8'(out_x), 8'(want.x), want);
        check_field("y", out_y, want.y, want);
        check_field("z", 8'(out_z), 8'(want.z), want);
        check_field("last_face", 8'(out_last_face), 8'(want.last), want);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    stim_row_t row;
    logic [26:0] a;
    logic [26:0] b;
    int r;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_DIRECTED; i++) send_block(DIRECTED_ROWS[i]);

    for (int i = 0; i < RANDOM_BLOCKS; i++) begin
      if (i % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      a = 27'($urandom);
      b = 27'($urandom);
      row = '0;
      case ($urandom_range(0, 7))
        0, 1: row.mask = a;
        2, 3: row.mask = a & b;
        4, 5: row.mask = a | b;
        6: begin
          // solid shell with each face neighbor opened at random
          row.mask = FULL_MASK;
          for (int f = 0; f < 6; f++) begin
            if ($urandom_range(0, 1) == 0)
              row.mask[(f >> 1 == 0 ? (f & 1) * 2 : 1) * 9 +
                       (f >> 1 == 1 ? (f & 1) * 2 : 1) * 3 +
                       (f >> 1 == 2 ? (f & 1) * 2 : 1)] = 1'b0;
          end
        end
        default: row.mask = ($urandom_range(0, 1) == 0) ? 27'h0 : (a | b) & (a | ~b);
      endcase
      row.kind = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      r = $urandom_range(0, 7);
      row.y = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      row.x = 4'($urandom_range(0, 15));
      row.z = 4'($urandom_range(0, 15));
      send_block(row);
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (pending_faces.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// File: files.f
src/vfc_pkg.sv
src/vfc_front.sv
src/vfc_queue.sv
src/vfc_back.sv
src/voxel_face_cull_ambient_occlusion_top.sv
test/tb_top.sv
